// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands; NO_ASSERTIONS compiles them away.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/vna_pkg.sv =====
// ----------------------------------------------------------------------------
// vna_pkg
// Item types, store entry types and command codes of the normal accumulator.
// ----------------------------------------------------------------------------
package vna_pkg;

	localparam int POS_W = 24;
	localparam int IDX_W = 10;
	localparam int NRM_W = 16;
	localparam int CNT_W = 16;
	localparam int SUM_W = 32;

	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_TRI   = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	localparam logic [CNT_W-1:0] COUNT_MAX = '1;

	typedef struct packed {
		logic [1:0]              cmd;
		logic [IDX_W-1:0]        vertex_index;
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic signed [POS_W-1:0] pos_z;
		logic [IDX_W-1:0]        corner_a;
		logic [IDX_W-1:0]        corner_b;
		logic [IDX_W-1:0]        corner_c;
	} vna_in_t;

	typedef struct packed {
		logic signed [NRM_W-1:0] normal_x;
		logic signed [NRM_W-1:0] normal_y;
		logic signed [NRM_W-1:0] normal_z;
		logic [CNT_W-1:0]        adjacent_count;
	} vna_out_t;

	typedef struct packed {
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic signed [POS_W-1:0] z;
	} pos_entry_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] sum_x;
		logic signed [SUM_W-1:0] sum_y;
		logic signed [SUM_W-1:0] sum_z;
		logic [CNT_W-1:0]        count;
	} acc_entry_t;

endpackage

// ===== src/vertex_normal_accumulator_top.sv =====
// ----------------------------------------------------------------------------
// vertex_normal_accumulator_top
// Averaged vertex normals: position store, per-triangle unit normal, read-out.
// ----------------------------------------------------------------------------
// A triangle reads its three corners, forms the cross product on one shared
// 31x31 multiplier, normalizes the largest component into [2^29, 2^30) one
// bit shift per cycle, squares and sums, takes a bit-serial square root, then
// runs three 45-step restoring divisions and three read-modify-writes; a
// degenerate triangle skips straight to the corner updates. A read runs three
// 34-step divisions, or none when the count is zero. The square root and
// divider retire one bit per cycle.
// in_ready is high only while the sequencer is idle. Results sit in an output
// register, so a new item may be taken while a result waits. Stores hold no
// reset value: a vertex must be written before it is used or read.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vertex_normal_accumulator_top
	import vna_pkg::*;
#(
	parameter int NUM_VERTICES = 1024
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  vna_in_t  in_item,
	output logic     out_valid,
	input  logic     out_ready,
	output vna_out_t out_item
);

	localparam int AW = (NUM_VERTICES > 1) ? $clog2(NUM_VERTICES) : 1;

	typedef enum logic [13:0] {
		S_IDLE   = 14'b00000000000001,
		S_LOAD   = 14'b00000000000010,
		S_EDGE   = 14'b00000000000100,
		S_CROSS  = 14'b00000000001000,
		S_MAG    = 14'b00000000010000,
		S_NORM   = 14'b00000000100000,
		S_SQ     = 14'b00000001000000,
		S_SQRT   = 14'b00000010000000,
		S_DIVLD  = 14'b00000100000000,
		S_DIVRUN = 14'b00001000000000,
		S_ACCRD  = 14'b00010000000000,
		S_ACCWR  = 14'b00100000000000,
		S_RDRD   = 14'b01000000000000,
		S_DONE   = 14'b10000000000000
	} state_t;

	function automatic logic in_range(input logic [IDX_W-1:0] idx);
		return 32'(idx) < NUM_VERTICES;
	endfunction

	// storage
	pos_entry_t pos_mem [NUM_VERTICES];
	acc_entry_t acc_mem [NUM_VERTICES];
	pos_entry_t pos_rd_q;
	acc_entry_t acc_rd_q;

	// control
	state_t         state_q;
	logic [1:0]     cmd_q;
	logic [5:0]     cnt_q;
	logic [1:0]     comp_q;
	logic [AW-1:0]  corner_q [3];
	logic [AW-1:0]  vi_q;
	logic           out_valid_q;
	vna_out_t       out_q;

	// datapath
	pos_entry_t            pa_q, pb_q, pc_q;
	logic signed [24:0]    e1_q [3];
	logic signed [24:0]    e2_q [3];
	logic signed [61:0]    p_q;
	logic signed [50:0]    c_q [3];
	logic [49:0]           a_q [3];
	logic                  neg_q [3];
	logic [49:0]           m_q;
	logic [63:0]           sq_q, res_q, bit_q;
	logic [47:0]           dnum_q;
	logic [31:0]           drem_q, dden_q;
	logic [15:0]           dquo_q;
	logic [5:0]            dlast_q;
	logic signed [15:0]    n_q [3];
	logic [CNT_W-1:0]      rcnt_q;

	// memory port controls
	logic          pos_re, acc_re, pos_we, acc_we;
	logic [AW-1:0] pos_ra, acc_ra, wr_a;
	pos_entry_t    pos_wd;
	acc_entry_t    acc_wd;

	// shared multiplier
	logic signed [30:0] mul_a, mul_b;
	logic signed [61:0] mul_p;

	// helper nets
	logic [2:0]         km1;
	logic [63:0]        sqrt_trial;
	logic [32:0]        div_sh;
	logic               qbit;
	logic [15:0]        qfull;
	logic [16:0]        qround;
	logic signed [31:0] rd_sum;
	logic [31:0]        rd_mag;
	logic [33:0]        rd_num;
	logic [49:0]        mag_c [3];
	logic [49:0]        max_ab;
	logic               accept;

	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag_c[i] = c_q[i][50] ? 50'(-c_q[i]) : 50'(c_q[i]);
		end
		max_ab = (mag_c[0] > mag_c[1]) ? mag_c[0] : mag_c[1];
	end

	// operand select: cross terms in CROSS, squares in SQ
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (state_q == S_CROSS) begin
			unique case (cnt_q[2:0])
				3'd0: begin mul_a = 31'(e1_q[1]); mul_b = 31'(e2_q[2]); end
				3'd1: begin mul_a = 31'(e1_q[2]); mul_b = 31'(e2_q[1]); end
				3'd2: begin mul_a = 31'(e1_q[2]); mul_b = 31'(e2_q[0]); end
				3'd3: begin mul_a = 31'(e1_q[0]); mul_b = 31'(e2_q[2]); end
				3'd4: begin mul_a = 31'(e1_q[0]); mul_b = 31'(e2_q[1]); end
				3'd5: begin mul_a = 31'(e1_q[1]); mul_b = 31'(e2_q[0]); end
				default: begin mul_a = '0; mul_b = '0; end
			endcase
		end else if (state_q == S_SQ && cnt_q[1:0] != 2'd3) begin
			mul_a = $signed({1'b0, a_q[cnt_q[1:0]][29:0]});
			mul_b = mul_a;
		end
	end
	assign mul_p = mul_a * mul_b;

	assign km1        = cnt_q[2:0] - 3'd1;
	assign sqrt_trial = res_q + bit_q;
	assign div_sh     = {drem_q, dnum_q[47]};
	assign qbit       = div_sh >= {1'b0, dden_q};
	assign qfull      = {dquo_q[14:0], qbit};
	assign qround     = {1'b0, qfull} + 17'd1;

	always_comb begin
		unique case (comp_q)
			2'd0:    rd_sum = acc_rd_q.sum_x;
			2'd1:    rd_sum = acc_rd_q.sum_y;
			default: rd_sum = acc_rd_q.sum_z;
		endcase
		rd_mag = rd_sum[31] ? 32'(-rd_sum) : 32'(rd_sum);
		rd_num = {1'b0, rd_mag, 1'b0} + 34'(acc_rd_q.count);
	end

	// memory port drive
	always_comb begin
		pos_re = (state_q == S_LOAD) && (cnt_q[1:0] != 2'd3);
		pos_ra = corner_q[cnt_q[1:0]];
		acc_re = (state_q == S_ACCRD) || (state_q == S_RDRD);
		acc_ra = (state_q == S_RDRD) ? vi_q : corner_q[comp_q];
		pos_we = accept && (in_item.cmd == CMD_WRITE) && in_range(in_item.vertex_index);
		pos_wd = '{x: in_item.pos_x, y: in_item.pos_y, z: in_item.pos_z};
		acc_we = pos_we;
		wr_a   = AW'(in_item.vertex_index);
		acc_wd = '0;
		if (state_q == S_ACCWR && acc_rd_q.count != COUNT_MAX) begin
			acc_we = 1'b1;
			wr_a   = corner_q[comp_q];
			acc_wd.sum_x = acc_rd_q.sum_x + 32'(n_q[0]);
			acc_wd.sum_y = acc_rd_q.sum_y + 32'(n_q[1]);
			acc_wd.sum_z = acc_rd_q.sum_z + 32'(n_q[2]);
			acc_wd.count = acc_rd_q.count + 16'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (pos_we) begin
			pos_mem[wr_a] <= pos_wd;
		end
		if (pos_re) begin
			pos_rd_q <= pos_mem[pos_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (acc_we) begin
			acc_mem[wr_a] <= acc_wd;
		end
		if (acc_re) begin
			acc_rd_q <= acc_mem[acc_ra];
		end
	end

	// sequencer and datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			comp_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
				out_q       <= '{normal_x: n_q[0], normal_y: n_q[1], normal_z: n_q[2],
					adjacent_count: rcnt_q};
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q       <= in_item.cmd;
						vi_q        <= AW'(in_item.vertex_index);
						corner_q[0] <= AW'(in_item.corner_a);
						corner_q[1] <= AW'(in_item.corner_b);
						corner_q[2] <= AW'(in_item.corner_c);
						cnt_q       <= '0;
						comp_q      <= '0;
						if (in_item.cmd == CMD_TRI && in_range(in_item.corner_a)
							&& in_range(in_item.corner_b) && in_range(in_item.corner_c)) begin
							state_q <= S_LOAD;
						end else if (in_item.cmd == CMD_READ) begin
							if (in_range(in_item.vertex_index)) begin
								state_q <= S_RDRD;
							end else begin
								for (int i = 0; i < 3; i++) n_q[i] <= '0;
								rcnt_q  <= '0;
								state_q <= S_DONE;
							end
						end
					end
				end
				S_LOAD: begin
					unique case (cnt_q[1:0])
						2'd1:    pa_q <= pos_rd_q;
						2'd2:    pb_q <= pos_rd_q;
						2'd3:    pc_q <= pos_rd_q;
						default: ;
					endcase
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q[1:0] == 2'd3) begin
						state_q <= S_EDGE;
					end
				end
				S_EDGE: begin
					e1_q[0] <= 25'(pb_q.x) - 25'(pa_q.x);
					e1_q[1] <= 25'(pb_q.y) - 25'(pa_q.y);
					e1_q[2] <= 25'(pb_q.z) - 25'(pa_q.z);
					e2_q[0] <= 25'(pc_q.x) - 25'(pa_q.x);
					e2_q[1] <= 25'(pc_q.y) - 25'(pa_q.y);
					e2_q[2] <= 25'(pc_q.z) - 25'(pa_q.z);
					for (int i = 0; i < 3; i++) c_q[i] <= '0;
					cnt_q   <= '0;
					state_q <= S_CROSS;
				end
				S_CROSS: begin
					p_q <= mul_p;
					if (cnt_q != 6'd0) begin
						if (km1[0]) c_q[km1[2:1]] <= c_q[km1[2:1]] - 51'(p_q);
						else        c_q[km1[2:1]] <= c_q[km1[2:1]] + 51'(p_q);
					end
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd6) begin
						state_q <= S_MAG;
					end
				end
				S_MAG: begin
					for (int i = 0; i < 3; i++) begin
						a_q[i]   <= mag_c[i];
						neg_q[i] <= c_q[i][50];
					end
					m_q     <= (max_ab > mag_c[2]) ? max_ab : mag_c[2];
					state_q <= S_NORM;
				end
				S_NORM: begin
					priority if (m_q == '0) begin
						// degenerate triangle: zero vector, corners still counted
						for (int i = 0; i < 3; i++) n_q[i] <= '0;
						comp_q  <= '0;
						state_q <= S_ACCRD;
					end else if (m_q[49:30] != '0) begin
						m_q <= m_q >> 1;
						for (int i = 0; i < 3; i++) a_q[i] <= a_q[i] >> 1;
					end else if (!m_q[29]) begin
						m_q <= m_q << 1;
						for (int i = 0; i < 3; i++) a_q[i] <= a_q[i] << 1;
					end else begin
						sq_q    <= '0;
						cnt_q   <= '0;
						state_q <= S_SQ;
					end
				end
				S_SQ: begin
					p_q <= mul_p;
					if (cnt_q != 6'd0) begin
						sq_q <= sq_q + 64'(unsigned'(p_q));
					end
					if (cnt_q == 6'd3) begin
						res_q   <= '0;
						bit_q   <= 64'd1 << 62;
						cnt_q   <= '0;
						state_q <= S_SQRT;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				S_SQRT: begin
					if (sq_q >= sqrt_trial) begin
						sq_q  <= sq_q - sqrt_trial;
						res_q <= (res_q >> 1) + bit_q;
					end else begin
						res_q <= res_q >> 1;
					end
					bit_q <= bit_q >> 2;
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd31) begin
						comp_q  <= '0;
						state_q <= S_DIVLD;
					end
				end
				S_DIVLD: begin
					drem_q <= '0;
					dquo_q <= '0;
					cnt_q  <= '0;
					if (cmd_q == CMD_TRI) begin
						// a * 2^15 / r
						dnum_q  <= {a_q[comp_q][29:0], 18'd0};
						dden_q  <= {1'b0, res_q[30:0]};
						dlast_q <= 6'd44;
						state_q <= S_DIVRUN;
					end else begin
						// (2|s| + n) / 2n; read entry registered during S_RDRD
						dnum_q  <= {rd_num, 14'd0};
						dden_q  <= {15'd0, acc_rd_q.count, 1'b0};
						neg_q[comp_q] <= rd_sum[31];
						dlast_q <= 6'd33;
						if (comp_q == 2'd0) begin
							rcnt_q <= acc_rd_q.count;
						end
						// zero count skips division
						if (acc_rd_q.count == '0) begin
							for (int i = 0; i < 3; i++) n_q[i] <= '0;
							state_q <= S_DONE;
						end else begin
							state_q <= S_DIVRUN;
						end
					end
				end
				S_DIVRUN: begin
					drem_q <= qbit ? 32'(div_sh - {1'b0, dden_q}) : div_sh[31:0];
					dquo_q <= qfull;
					dnum_q <= dnum_q << 1;
					cnt_q  <= cnt_q + 6'd1;
					if (cnt_q == dlast_q) begin
						if (cmd_q == CMD_TRI) begin
							n_q[comp_q] <= neg_q[comp_q] ? -qround[16:1] : qround[16:1];
						end else begin
							n_q[comp_q] <= neg_q[comp_q] ? -qfull : qfull;
						end
						if (comp_q == 2'd2) begin
							comp_q  <= '0;
							state_q <= (cmd_q == CMD_TRI) ? S_ACCRD : S_DONE;
						end else begin
							comp_q  <= comp_q + 2'd1;
							state_q <= S_DIVLD;
						end
					end
				end
				S_ACCRD: begin
					state_q <= S_ACCWR;
				end
				S_ACCWR: begin
					// corners in turn, so a repeated corner sees its own update
					if (comp_q == 2'd2) begin
						state_q <= S_IDLE;
					end else begin
						comp_q  <= comp_q + 2'd1;
						state_q <= S_ACCRD;
					end
				end
				S_RDRD: begin
					state_q <= S_DIVLD;
					comp_q  <= '0;
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`ASSERT_IMPLIES(a_zero_count, clk, arst_n, out_valid && out_item.adjacent_count == '0, out_item.normal_x == '0 && out_item.normal_y == '0 && out_item.normal_z == '0)
	`ASSERT_IMPLIES(a_sat_hold, clk, arst_n, acc_we && state_q == S_ACCWR, acc_rd_q.count != COUNT_MAX)
	`ASSERT_NEXT(a_sqrt_run, clk, arst_n, state_q == S_SQRT && cnt_q != 6'd31, state_q == S_SQRT)

endmodule

// ===== tb/vertex_normal_accumulator_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vertex_normal_accumulator_top_tb
// Self-checking bench: drives vertex writes, triangles and reads through the
// valid/ready input, predicts each averaged normal in an independent model of
// the stores, and compares every result item in order. Covers extremes, a
// degenerate triangle, repeated corners, the unused command, and random
// traffic with bursty input and output stalls.
// ----------------------------------------------------------------------------
module vertex_normal_accumulator_top_tb;
	import vna_pkg::*;

	localparam int NV         = 1024;
	localparam int LIMIT      = 5000000;
	localparam int HOLD_LEN   = 4000;
	localparam int DRAIN_WAIT = 400;
	localparam int RAND_ITEMS = 1830;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam logic signed [POS_W-1:0] PMAX = 24'sh7FFFFF;
	localparam logic signed [POS_W-1:0] PMIN = -24'sh800000;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     in_valid = 1'b0;
	logic     in_ready;
	vna_in_t  in_item = '0;
	logic     out_valid;
	logic     out_ready = 1'b0;
	vna_out_t out_item;

	vertex_normal_accumulator_top #(.NUM_VERTICES(NV)) DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// shadow copy of the vertex and accumulator stores
	pos_entry_t  shadow_pos[NV];
	int          shadow_sum_x[NV];
	int          shadow_sum_y[NV];
	int          shadow_sum_z[NV];
	int unsigned shadow_cnt[NV];
	bit          written[NV];
	int          written_list[$];

	vna_out_t pending_normals[$];
	int       mismatches = 0;
	int       cycle_count = 0;
	bit       hold_req = 1'b0;

	// directed rows: typed expectation only where it is obvious by hand
	typedef struct {
		vna_in_t  item;
		bit       typed;
		vna_out_t want;
	} stim_row_t;
	stim_row_t directed_rows[$];

	function automatic longint unsigned floor_sqrt(input longint unsigned n);
		longint unsigned res = 0;
		longint unsigned b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic longint unsigned magnitude(input longint v);
		return v < 0 ? longint'(-v) : longint'(v);
	endfunction

	// cross product scaled so the largest magnitude sits in [2^29, 2^30),
	// then divided by the rounded-down root, rounding half up
	task automatic unit_face_normal(input longint cr[3], output int nrm[3]);
		longint unsigned mag[3];
		longint unsigned big, sq, r, q;
		big = 0;
		sq = 0;
		for (int i = 0; i < 3; i++) begin
			mag[i] = magnitude(cr[i]);
			if (mag[i] > big) big = mag[i];
		end
		if (big == 0) begin
			nrm = '{0, 0, 0};
			return;
		end
		while (big >= (64'd1 << 30)) begin
			big >>= 1;
			for (int i = 0; i < 3; i++) mag[i] >>= 1;
		end
		while (big < (64'd1 << 29)) begin
			big <<= 1;
			for (int i = 0; i < 3; i++) mag[i] <<= 1;
		end
		for (int i = 0; i < 3; i++) sq += mag[i] * mag[i];
		r = floor_sqrt(sq);
		for (int i = 0; i < 3; i++) begin
			q = (mag[i] * 64'd32768 / r + 1) / 2;
			nrm[i] = cr[i] < 0 ? -int'(q) : int'(q);
		end
	endtask

	function automatic int round_avg(input int s, input int unsigned c);
		longint unsigned m, q;
		m = magnitude(longint'(s));
		q = (2 * m + c) / (2 * longint'(c));
		return s < 0 ? -int'(q) : int'(q);
	endfunction

	task automatic predict_normal(input vna_in_t it, output bit has_res, output vna_out_t res);
		int          corner[3];
		longint      e1[3], e2[3], cr[3];
		int          nrm[3];
		int unsigned c;
		has_res = 1'b0;
		res = '0;
		case (it.cmd)
			CMD_WRITE: begin
				shadow_pos[it.vertex_index] = '{it.pos_x, it.pos_y, it.pos_z};
				shadow_sum_x[it.vertex_index] = 0;
				shadow_sum_y[it.vertex_index] = 0;
				shadow_sum_z[it.vertex_index] = 0;
				shadow_cnt[it.vertex_index] = 0;
			end
			CMD_TRI: begin
				corner = '{int'(it.corner_a), int'(it.corner_b), int'(it.corner_c)};
				e1[0] = longint'($signed(shadow_pos[corner[1]].x)) - longint'($signed(shadow_pos[corner[0]].x));
				e1[1] = longint'($signed(shadow_pos[corner[1]].y)) - longint'($signed(shadow_pos[corner[0]].y));
				e1[2] = longint'($signed(shadow_pos[corner[1]].z)) - longint'($signed(shadow_pos[corner[0]].z));
				e2[0] = longint'($signed(shadow_pos[corner[2]].x)) - longint'($signed(shadow_pos[corner[0]].x));
				e2[1] = longint'($signed(shadow_pos[corner[2]].y)) - longint'($signed(shadow_pos[corner[0]].y));
				e2[2] = longint'($signed(shadow_pos[corner[2]].z)) - longint'($signed(shadow_pos[corner[0]].z));
				cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
				cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
				cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
				unit_face_normal(cr, nrm);
				// corners in turn: a repeated corner collects twice
				for (int k = 0; k < 3; k++) begin
					if (shadow_cnt[corner[k]] < 65535) begin
						shadow_sum_x[corner[k]] += nrm[0];
						shadow_sum_y[corner[k]] += nrm[1];
						shadow_sum_z[corner[k]] += nrm[2];
						shadow_cnt[corner[k]]++;
					end
				end
			end
			CMD_READ: begin
				has_res = 1'b1;
				c = shadow_cnt[it.vertex_index];
				res.adjacent_count = c[CNT_W-1:0];
				if (c != 0) begin
					res.normal_x = NRM_W'(round_avg(shadow_sum_x[it.vertex_index], c));
					res.normal_y = NRM_W'(round_avg(shadow_sum_y[it.vertex_index], c));
					res.normal_z = NRM_W'(round_avg(shadow_sum_z[it.vertex_index], c));
				end
			end
			default: ;
		endcase
	endtask

	function automatic vna_in_t mk_item(input logic [1:0] cmd, input int idx,
			input logic signed [POS_W-1:0] x, y, z, input int a, b, c);
		vna_in_t it;
		it = '{cmd, idx[IDX_W-1:0], x, y, z, a[IDX_W-1:0], b[IDX_W-1:0], c[IDX_W-1:0]};
		return it;
	endfunction

	function automatic vna_out_t mk_out(input int nx, ny, nz, cnt);
		vna_out_t o;
		o = '{nx[NRM_W-1:0], ny[NRM_W-1:0], nz[NRM_W-1:0], cnt[CNT_W-1:0]};
		return o;
	endfunction

	task automatic add_row(input vna_in_t it, input bit typed = 0, input vna_out_t want = '0);
		stim_row_t r;
		r.item = it;
		r.typed = typed;
		r.want = want;
		directed_rows.insert(directed_rows.size(), r);
	endtask

	// drives one item and returns at the edge where it is taken
	task automatic send_item(input vna_in_t it, input bit typed = 0, input vna_out_t want = '0);
		bit       has_res;
		vna_out_t res;
		in_valid <= 1'b1;
		in_item <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_normal(it, has_res, res);
		if (it.cmd == CMD_WRITE && !written[it.vertex_index]) begin
			written[it.vertex_index] = 1'b1;
			written_list.insert(written_list.size(), int'(it.vertex_index));
		end
		if (has_res) pending_normals.insert(pending_normals.size(), typed ? want : res);
	endtask

	task automatic idle_cycles(input int n);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_normals.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	function automatic logic signed [POS_W-1:0] rand_coord();
		logic [31:0] r;
		r = $urandom;
		case ($urandom_range(0, 7))
			0: return PMAX;
			1: return PMIN;
			2, 3, 4: return POS_W'($signed(r[15:0]));	// local geometry, small edges
			default: return r[POS_W-1:0];
		endcase
	endfunction

	function automatic int pick_vertex();
		return written_list[$urandom_range(0, written_list.size() - 1)];
	endfunction

	function automatic vna_in_t rand_item();
		vna_in_t it;
		int      sel;
		// noise in the unused fields
		it = '0;
		it.vertex_index = IDX_W'($urandom);
		it.pos_x = POS_W'($urandom);
		it.pos_y = POS_W'($urandom);
		it.pos_z = POS_W'($urandom);
		it.corner_a = IDX_W'($urandom);
		it.corner_b = IDX_W'($urandom);
		it.corner_c = IDX_W'($urandom);
		sel = $urandom_range(0, 99);
		if (sel < 25) begin
			it.cmd = CMD_WRITE;
			// mostly a small working set so counts build up
			it.vertex_index = ($urandom_range(0, 3) == 0) ? IDX_W'($urandom)
				: IDX_W'($urandom_range(0, 47));
			it.pos_x = rand_coord();
			it.pos_y = rand_coord();
			it.pos_z = rand_coord();
		end else if (sel < 65) begin
			it.cmd = CMD_TRI;
			it.corner_a = IDX_W'(pick_vertex());
			it.corner_b = IDX_W'(pick_vertex());
			it.corner_c = IDX_W'(pick_vertex());
		end else if (sel < 95) begin
			it.cmd = CMD_READ;
			it.vertex_index = IDX_W'(pick_vertex());
		end else begin
			it.cmd = CMD_UNUSED;
		end
		return it;
	endfunction

	// output side: checks results, stalls on its own pattern
	initial begin
		int       hold_left;
		int       mode;
		int       phase;
		vna_out_t want;
		hold_left = 0;
		mode = 0;
		phase = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (pending_normals.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result item: %h", out_item);
				end else begin
					want = pending_normals.pop_front();
					if (out_item !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: nx %0d/%0d ny %0d/%0d nz %0d/%0d cnt %0d/%0d (exp/got)",
								want.normal_x, out_item.normal_x, want.normal_y, out_item.normal_y,
								want.normal_z, out_item.normal_z, want.adjacent_count,
								out_item.adjacent_count);
					end
				end
			end
			if (hold_left == 0 && hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_LEN;
			end
			if (phase == 0) begin
				mode = $urandom_range(0, 3);
				phase = $urandom_range(16, 400);
			end
			phase--;
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					2: out_ready <= (phase % 5 == 0);
					default: out_ready <= ($urandom_range(0, 9) != 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		int burst;
		int calm;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part
		add_row(mk_item(CMD_WRITE, 0, 0, 0, 0, 0, 0, 0));
		add_row(mk_item(CMD_WRITE, 1023, PMAX, 0, 0, 0, 0, 0));
		add_row(mk_item(CMD_WRITE, 1, 0, PMAX, 0, 0, 0, 0));
		add_row(mk_item(CMD_WRITE, 2, PMIN, PMIN, PMIN, 0, 0, 0));
		add_row(mk_item(CMD_READ, 0, 0, 0, 0, 0, 0, 0), 1, mk_out(0, 0, 0, 0));
		add_row(mk_item(CMD_READ, 1023, 0, 0, 0, 0, 0, 0), 1, mk_out(0, 0, 0, 0));
		// full-scale edges along x and y give a pure +z unit normal
		add_row(mk_item(CMD_TRI, 0, 0, 0, 0, 0, 1023, 1));
		add_row(mk_item(CMD_READ, 0, 0, 0, 0, 0, 0, 0), 1, mk_out(0, 0, 16384, 1));
		// degenerate triangle, one corner three times: zero vector, counted thrice
		add_row(mk_item(CMD_TRI, 0, 0, 0, 0, 0, 0, 0));
		add_row(mk_item(CMD_READ, 0, 0, 0, 0, 0, 0, 0), 1, mk_out(0, 0, 4096, 4));
		add_row(mk_item(CMD_TRI, 0, 0, 0, 0, 1023, 2, 1));
		add_row(mk_item(CMD_TRI, 0, 0, 0, 0, 0, 1, 1));
		add_row('1);	// unused command, all bits high
		add_row(mk_item(CMD_READ, 1, 0, 0, 0, 0, 0, 0));
		add_row(mk_item(CMD_READ, 2, 0, 0, 0, 0, 0, 0));
		// rewrite clears sums and count
		add_row(mk_item(CMD_WRITE, 0, 1, -1, 1, 0, 0, 0));
		add_row(mk_item(CMD_READ, 0, 0, 0, 0, 0, 0, 0), 1, mk_out(0, 0, 0, 0));
		add_row(mk_item(CMD_WRITE, 3, PMIN, PMAX, 0, 0, 0, 0));
		add_row(mk_item(CMD_TRI, 0, 0, 0, 0, 2, 3, 1023));
		add_row(mk_item(CMD_READ, 1023, 0, 0, 0, 0, 0, 0));
		add_row(mk_item(CMD_READ, 3, 0, 0, 0, 0, 0, 0));
		foreach (directed_rows[i]) begin
			send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
			idle_cycles($urandom_range(0, 1) ? 0 : $urandom_range(1, 30));
		end
		wait_drained();

		// random part: bursts with gaps, some stretches without gaps
		burst = 0;
		calm = 0;
		for (int n = 0; n < RAND_ITEMS; n++) begin
			if (n == RAND_ITEMS / 3) hold_req = 1'b1;	// output backs up, input stalls
			if (n == RAND_ITEMS / 2) wait_drained();
			send_item(rand_item());
			if (calm > 0) begin
				calm--;
			end else if (burst > 0) begin
				burst--;
			end else begin
				idle_cycles($urandom_range(1, 60));
				burst = $urandom_range(1, 12);
				if ($urandom_range(0, 5) == 0) calm = $urandom_range(20, 80);
			end
		end
		wait_drained();

		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+src
src/vna_pkg.sv
src/vertex_normal_accumulator_top.sv
tb/vertex_normal_accumulator_top_tb.sv
